// ===== design/animation_frame_timer_defines.svh =====
// assertion macros for the animation frame timer
// used by the controller and datapath modules; no other dependencies
`ifndef ANIMATION_FRAME_TIMER_DEFINES_SVH
`define ANIMATION_FRAME_TIMER_DEFINES_SVH

`ifndef ASSERT_OFF
`define AFT_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);
`define AFT_ASSERT(lbl, prop, msg) `AFT_ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define AFT_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg)
`define AFT_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== design/aft_pkg.sv =====
// shared types and constants for the animation frame timer
// no dependencies
package aft_pkg;

	localparam int DUR_W   = 24;
	localparam int MODE_W  = 3;
	localparam int FC_W    = 9;
	localparam int CMD_W   = 3;
	localparam int FI_W    = 8;
	localparam int IDX_W   = 2;
	localparam int IN_W    = 56;
	localparam int OUT_W   = 40;
	localparam int DIV_STEPS = FC_W;
	localparam int CNT_W   = $clog2(DIV_STEPS);

	localparam logic [DUR_W-1:0] DUR_RESET    = DUR_W'(4096);
	localparam logic [FC_W-1:0]  FRAMES_RESET = FC_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_STEP    = 3'd0,
		CMD_PAUSE   = 3'd1,
		CMD_PLAY    = 3'd2,
		CMD_RESTART = 3'd3,
		CMD_LOAD    = 3'd4
	} cmd_code_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOOP     = 3'd0,
		MODE_REV      = 3'd1,
		MODE_PP       = 3'd2,
		MODE_ONCE     = 3'd3,
		MODE_ONCE_REV = 3'd4
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DURATION = 2'd0,
		REG_MODE     = 2'd1,
		REG_FRAMES   = 2'd2
	} reg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic decode;
		logic add;
		logic fold;
		logic mul;
		logic dinit;
		logic div;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic step_go;
	} dp_status_t;

endpackage

// ===== design/aft_ctrl.sv =====
// sequencer for the animation frame timer
// depends on aft_pkg and animation_frame_timer_defines.svh
`include "animation_frame_timer_defines.svh"

module aft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  aft_pkg::dp_status_t st,
	output aft_pkg::dp_cmd_t    cmd
);
	import aft_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC,
		ST_ADD,
		ST_FOLD,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             slot_free;

	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.decode   = (state_q == ST_DEC);
		cmd.add      = (state_q == ST_ADD);
		cmd.fold     = (state_q == ST_FOLD);
		cmd.mul      = (state_q == ST_MUL);
		cmd.dinit    = (state_q == ST_DINIT);
		cmd.div      = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_DEC;
				end
				ST_DEC: begin
					state_q <= st.step_go ? ST_ADD : ST_MUL;
				end
				ST_ADD:   state_q <= ST_FOLD;
				ST_FOLD:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_DINIT;
				ST_DINIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`AFT_ASSERT(a_one_at_a_time, accept |=> !s_tready, "item accepted while one is in flight")
	`AFT_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_valid_q || m_tready),
		"pending result overwritten")
	`AFT_ASSERT(a_div_count, (state_q == ST_DIV) |-> (cnt_q <= CNT_W'(DIV_STEPS - 1)),
		"divider step count out of range")
	`AFT_ASSERT(a_valid_from_load, $rose(out_valid_q) |-> $past(cmd.load_out),
		"result valid without a load")

endmodule

// ===== design/aft_dpath.sv =====
// datapath of the animation frame timer: config, playback state, step and frame divider
// depends on aft_pkg and animation_frame_timer_defines.svh
`include "animation_frame_timer_defines.svh"

module aft_dpath #(
	parameter int TIME_BITS  = 24,
	parameter int MAX_FRAMES = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [aft_pkg::IDX_W-1:0]  cfg_index,
	input  logic [aft_pkg::DUR_W-1:0]  cfg_data,
	input  logic [aft_pkg::CMD_W-1:0]  command,
	input  logic [aft_pkg::DUR_W-1:0]  delta_ticks,
	input  logic [aft_pkg::DUR_W-1:0]  new_time,
	input  aft_pkg::dp_cmd_t           cmd,
	output aft_pkg::dp_status_t        st,
	output logic [aft_pkg::FI_W-1:0]   frame_index,
	output logic [aft_pkg::DUR_W-1:0]  time_now,
	output logic                       is_reversing,
	output logic                       is_paused
);
	import aft_pkg::*;

	localparam int PW     = (TIME_BITS < DUR_W) ? TIME_BITS : DUR_W;
	localparam int SW     = PW + 2;
	localparam int FC_MAX = (1 << FC_W) - 1;
	localparam logic [FC_W-1:0] FCAP = FC_W'((MAX_FRAMES > FC_MAX) ? FC_MAX : MAX_FRAMES);

	// configuration
	logic [DUR_W-1:0]  dur_q;
	logic [MODE_W-1:0] mode_q;
	logic [FC_W-1:0]   frames_q;

	// playback state
	logic [PW-1:0] pos_q;
	logic          bwd_q;
	logic          halt_q;

	// per item
	logic [CMD_W-1:0]     cmdc_q;
	logic [DUR_W-1:0]     dt_q;
	logic [DUR_W-1:0]     nt_q;
	logic [PW-1:0]        dtc_q;
	logic signed [SW-1:0] t_q;
	logic [PW+FC_W-1:0]   prod_q;
	logic [PW-1:0]        rem_q;
	logic [FC_W-1:0]      low_q;
	logic [FC_W-1:0]      quo_q;

	logic [FI_W-1:0]  fi_q;
	logic [DUR_W-1:0] tn_q;
	logic             rev_q;
	logic             pau_q;

	logic [PW-1:0]        d_raw;
	logic [PW-1:0]        eff_d;
	logic [FC_W-1:0]      f_eff;
	logic                 backward;
	logic signed [SW-1:0] d_s;
	logic signed [SW-1:0] d2_s;
	logic                 t_ge;
	logic                 t_le;
	logic signed [SW-1:0] fold_t;
	logic                 fold_bwd;
	logic [PW:0]          trial;
	logic [PW:0]          diff;
	logic                 q_bit;
	logic [FC_W-1:0]      idx;

	assign d_raw = dur_q[PW-1:0];
	assign eff_d = (d_raw == '0) ? PW'(1) : d_raw;

	always_comb begin
		if (frames_q == '0)
			f_eff = FC_W'(1);
		else if (frames_q > FCAP)
			f_eff = FCAP;
		else
			f_eff = frames_q;
	end

	assign st.step_go = (cmdc_q == CMD_STEP) && !halt_q;

	assign backward = (mode_q == MODE_REV) || (mode_q == MODE_ONCE_REV) || bwd_q;

	// wrap, reflect or clamp of the moved position
	assign d_s  = $signed({2'b00, eff_d});
	assign d2_s = $signed({1'b0, eff_d, 1'b0});
	assign t_ge = (t_q >= d_s);
	assign t_le = t_q[SW-1] || (t_q == '0);

	always_comb begin
		fold_t   = t_q;
		fold_bwd = bwd_q;
		unique case (mode_q)
			MODE_PP: begin
				if (t_ge) begin
					fold_t   = d2_s - t_q;
					fold_bwd = 1'b1;
				end else if (t_le) begin
					fold_t   = -t_q;
					fold_bwd = 1'b0;
				end
			end
			MODE_ONCE, MODE_ONCE_REV: begin
				if (t_ge)
					fold_t = d_s;
				else if (t_le)
					fold_t = '0;
			end
			default: begin
				// loop and reverse; exact zero wraps to the end
				if (t_ge)
					fold_t = t_q - d_s;
				else if (t_le)
					fold_t = d_s + t_q;
			end
		endcase
	end

	// restoring divider, one quotient bit per cycle
	assign trial = {rem_q, low_q[FC_W-1]};
	assign diff  = trial - {1'b0, eff_d};
	assign q_bit = (trial >= {1'b0, eff_d});

	assign idx = (quo_q >= f_eff) ? (f_eff - FC_W'(1)) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q    <= DUR_RESET;
			mode_q   <= MODE_LOOP;
			frames_q <= FRAMES_RESET;
			pos_q    <= '0;
			bwd_q    <= 1'b0;
			halt_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DURATION: begin
						dur_q  <= cfg_data;
						pos_q  <= '0;
						bwd_q  <= 1'b0;
						halt_q <= 1'b0;
					end
					REG_MODE: mode_q <= cfg_data[MODE_W-1:0];
					REG_FRAMES: begin
						frames_q <= cfg_data[FC_W-1:0];
						pos_q    <= '0;
						bwd_q    <= 1'b0;
						halt_q   <= 1'b0;
					end
					default: ;
				endcase
			end else if (cmd.decode) begin
				unique case (cmdc_q)
					CMD_PAUSE: halt_q <= 1'b1;
					CMD_PLAY:  halt_q <= 1'b0;
					CMD_RESTART: begin
						pos_q  <= '0;
						bwd_q  <= 1'b0;
						halt_q <= 1'b0;
					end
					CMD_LOAD: begin
						pos_q <= (nt_q > DUR_W'(eff_d)) ? eff_d : nt_q[PW-1:0];
					end
					default: ;
				endcase
			end else if (cmd.fold) begin
				pos_q <= fold_t[PW-1:0];
				bwd_q <= fold_bwd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmdc_q <= command;
			dt_q   <= delta_ticks;
			nt_q   <= new_time;
		end
		if (cmd.decode)
			dtc_q <= (dt_q > DUR_W'(eff_d)) ? eff_d : dt_q[PW-1:0];
		if (cmd.add) begin
			if (backward)
				t_q <= $signed({2'b00, pos_q}) - $signed({2'b00, dtc_q});
			else
				t_q <= $signed({2'b00, pos_q}) + $signed({2'b00, dtc_q});
		end
		if (cmd.mul)
			prod_q <= (PW+FC_W)'(pos_q) * (PW+FC_W)'(f_eff);
		if (cmd.dinit) begin
			rem_q <= prod_q[PW+FC_W-1:FC_W];
			low_q <= prod_q[FC_W-1:0];
			quo_q <= '0;
		end
		if (cmd.div) begin
			rem_q <= q_bit ? diff[PW-1:0] : trial[PW-1:0];
			low_q <= {low_q[FC_W-2:0], 1'b0};
			quo_q <= {quo_q[FC_W-2:0], q_bit};
		end
		if (cmd.load_out) begin
			fi_q  <= idx[FI_W-1:0];
			tn_q  <= DUR_W'(pos_q);
			rev_q <= bwd_q;
			pau_q <= halt_q;
		end
	end

	assign frame_index  = fi_q;
	assign time_now     = tn_q;
	assign is_reversing = rev_q;
	assign is_paused    = pau_q;

	`AFT_ASSERT(a_pos_in_range, pos_q <= eff_d, "position beyond duration")
	`AFT_ASSERT(a_rem_below_div, cmd.div |-> (rem_q < eff_d), "divider remainder not reduced")
	`AFT_ASSERT(a_frame_in_range, cmd.load_out |-> (idx < f_eff), "frame index beyond frame count")

endmodule

// ===== design/animation_frame_timer.sv =====
// animation frame timer top level: stream ports, config port, controller and datapath
// depends on aft_pkg, aft_ctrl and aft_dpath
//
// channel   direction  contents
// s_*       in         command, delta_ticks, new_time
// m_*       out        frame_index, time_now, is_reversing, is_paused
// cfg_*     in         anim_duration, play_mode, frame_count writes
//
// one item at a time: an unpaused step passes the states DEC, ADD, FOLD, MUL, DINIT,
// DIV and DONE, other commands skip ADD and FOLD, and DONE loads the output register;
// the nine-step restoring divider for the frame index is the longest part. a new item is
// taken while the previous result waits in the output register; the one after waits
// until that result is taken. reset (arst_n low) clears position, flags and config to
// their defaults; writing duration or frame count restarts playback.
module animation_frame_timer #(
	parameter int TIME_BITS  = 24,
	parameter int MAX_FRAMES = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [2:0] command, [26:3] delta_ticks, [50:27] new_time, rest zero
	input  logic [aft_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [7:0] frame_index, [31:8] time_now, [32] is_reversing, [33] is_paused, rest zero
	output logic [aft_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       cfg_we,
	input  logic [aft_pkg::IDX_W-1:0]  cfg_index,
	input  logic [aft_pkg::DUR_W-1:0]  cfg_data
);
	import aft_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	logic [FI_W-1:0]  frame_index;
	logic [DUR_W-1:0] time_now;
	logic             is_reversing;
	logic             is_paused;

	aft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	aft_dpath #(
		.TIME_BITS  (TIME_BITS),
		.MAX_FRAMES (MAX_FRAMES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (s_tdata[CMD_W-1:0]),
		.delta_ticks  (s_tdata[CMD_W+DUR_W-1:CMD_W]),
		.new_time     (s_tdata[CMD_W+2*DUR_W-1:CMD_W+DUR_W]),
		.cmd          (cmd),
		.st           (st),
		.frame_index  (frame_index),
		.time_now     (time_now),
		.is_reversing (is_reversing),
		.is_paused    (is_paused)
	);

	assign m_tdata = {6'b0, is_paused, is_reversing, time_now, frame_index};

endmodule
